// ----- rtl/ubrp_pkg.sv -----
// Shared constants and types for the USB bulk-IN ring packetizer.
`default_nettype none
package ubrp_pkg;

	// Ring geometry: positions wrap naturally at the ring size.
	localparam int unsigned RING_DEPTH = 2048;
	localparam int unsigned POS_W      = $clog2(RING_DEPTH);

	// Field widths of the item and result ports.
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned FRAME_W = 8;
	localparam int unsigned LEN_W   = 11;

	// A block whose length is a multiple of the packet size ends with a zero-length packet.
	localparam int unsigned ZLP_UNIT = 64;
	localparam int unsigned ZLP_W    = $clog2(ZLP_UNIT);

	// Largest block that is ever offered.
	localparam logic [LEN_W-1:0] MAX_BLOCK = LEN_W'(1024);

	// Register file: two registers on a 32-bit data bus at word-aligned byte addresses.
	localparam int unsigned DATA_W = 32;
	localparam int unsigned ADDR_W = 3;

	localparam logic [FRAME_W-1:0] FRAME_INTERVAL_RST = FRAME_W'(5);
	localparam logic [LEN_W-1:0]   BLOCK_LIMIT_RST    = LEN_W'(512);

	typedef enum logic {
		REG_FRAME_INTERVAL = 1'b0,
		REG_BLOCK_LIMIT    = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ACT_PUSH = 2'd0,
		ACT_TICK = 2'd1,
		ACT_READ = 2'd2
	} action_t;

	// Result fields that travel from the first stage to the output register.
	typedef struct packed {
		logic             push_taken;
		logic             send_valid;
		logic [POS_W-1:0] send_offset;
		logic [LEN_W-1:0] send_length;
		logic             zero_length_packet;
		logic             is_read;
	} stage_t;

endpackage
`default_nettype wire

// ----- rtl/ubrp_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module ubrp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/usb_bulk_in_ring_packetizer_core.sv -----
// Top level of the USB bulk-IN transmit ring packetizer.
// The block takes one request per clock cycle while item_stall is low. On acceptance the ring
// pointers update and transfers are scheduled into the first stage; the result register then
// adds the byte read from the 2048-entry ring RAM, whose registered read port lines up with the
// first stage. A result register and the first stage part the two sides, so one more request
// is taken while a finished result waits. A push stores one byte unless the ring is full; a
// frame tick counts frames and, at each scheduling point with the endpoint idle, retires the
// last accepted block and offers either a zero-length packet or the next contiguous block; a
// read returns one stored byte. Reading a ring position never pushed returns an unspecified
// byte. Registers: frame_interval at byte address 0, block_limit at byte address 4.
`default_nettype none
module usb_bulk_in_ring_packetizer_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Configuration port.
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [ubrp_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [ubrp_pkg::DATA_W-1:0]   pwdata,
	output logic      [ubrp_pkg::DATA_W-1:0]   prdata,
	output logic                               pready,
	// Request channel.
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire logic [1:0]                    action,
	input  wire logic [ubrp_pkg::BYTE_W-1:0]   data_byte,
	input  wire logic                          endpoint_idle,
	input  wire logic                          endpoint_accepts,
	input  wire logic [ubrp_pkg::POS_W-1:0]    read_index,
	// Result channel.
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic                               push_taken,
	output logic      [ubrp_pkg::POS_W-1:0]    free_space,
	output logic                               send_valid,
	output logic      [ubrp_pkg::POS_W-1:0]    send_offset,
	output logic      [ubrp_pkg::LEN_W-1:0]    send_length,
	output logic                               zero_length_packet,
	output logic      [ubrp_pkg::BYTE_W-1:0]   read_data
);

	localparam int unsigned POS_W  = ubrp_pkg::POS_W;
	localparam int unsigned LEN_W  = ubrp_pkg::LEN_W;
	localparam int unsigned BYTE_W = ubrp_pkg::BYTE_W;

	// Configuration registers.
	logic [ubrp_pkg::FRAME_W-1:0] frame_interval_q;
	logic [LEN_W-1:0]             block_limit_q;

	// Ring control state.
	logic [POS_W-1:0]             write_pos_q;
	logic [POS_W-1:0]             read_pos_q;
	logic [LEN_W-1:0]             pending_len_q;
	logic [ubrp_pkg::FRAME_W-1:0] frame_count_q;

	// Pipeline state.
	logic                         valid_s1;
	ubrp_pkg::stage_t             stage_s1;
	logic                         out_valid_q;
	ubrp_pkg::stage_t             out_q;
	logic [POS_W-1:0]             free_q;
	logic [BYTE_W-1:0]            read_data_q;

	// Handshake and next-state signals.
	logic                         accept;
	logic                         out_free;
	logic                         s1_advance;
	logic                         cfg_write;
	logic [POS_W-1:0]             write_pos_d;
	logic [POS_W-1:0]             read_pos_d;
	logic [LEN_W-1:0]             pending_len_d;
	logic [ubrp_pkg::FRAME_W-1:0] frame_count_d;
	ubrp_pkg::stage_t             stage_d;
	logic                         ram_wr_en;
	logic [BYTE_W-1:0]            ram_rd_data;

	// Scheduling helpers.
	logic                         ring_full;
	logic                         fire;
	logic [POS_W-1:0]             retired_pos;
	logic                         need_zlp;
	logic [LEN_W-1:0]             limit;
	logic [POS_W:0]               run_len;
	logic [LEN_W-1:0]             block_len;

	// Configuration port: always ready, registers decoded by one address bit.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_interval_q <= ubrp_pkg::FRAME_INTERVAL_RST;
			block_limit_q    <= ubrp_pkg::BLOCK_LIMIT_RST;
		end else if (cfg_write) begin
			case (ubrp_pkg::reg_idx_t'(paddr[2]))
				ubrp_pkg::REG_FRAME_INTERVAL: begin
					frame_interval_q <= pwdata[ubrp_pkg::FRAME_W-1:0];
				end
				ubrp_pkg::REG_BLOCK_LIMIT: begin
					block_limit_q <= pwdata[LEN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (ubrp_pkg::reg_idx_t'(paddr[2]))
			ubrp_pkg::REG_FRAME_INTERVAL: begin
				prdata = {{(ubrp_pkg::DATA_W - ubrp_pkg::FRAME_W){1'b0}}, frame_interval_q};
			end
			ubrp_pkg::REG_BLOCK_LIMIT: begin
				prdata = {{(ubrp_pkg::DATA_W - LEN_W){1'b0}}, block_limit_q};
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	// Flow control: the first stage moves on when the result register is empty or being taken.
	assign out_free   = !out_valid_q || !result_stall;
	assign s1_advance = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;
	assign accept     = item_valid && !item_stall;

	// Block size helpers: clamp the limit, find the contiguous run after the retired block.
	always_comb begin
		if (block_limit_q == '0) begin
			limit = LEN_W'(1);
		end else if (block_limit_q > ubrp_pkg::MAX_BLOCK) begin
			limit = ubrp_pkg::MAX_BLOCK;
		end else begin
			limit = block_limit_q;
		end
		ring_full   = (write_pos_q + POS_W'(1)) == read_pos_q;
		fire        = frame_count_q == frame_interval_q;
		retired_pos = read_pos_q + pending_len_q[POS_W-1:0];
		need_zlp    = (pending_len_q != '0) && (pending_len_q[ubrp_pkg::ZLP_W-1:0] == '0);
		if (retired_pos > write_pos_q) begin
			run_len = (POS_W+1)'(ubrp_pkg::RING_DEPTH) - {1'b0, retired_pos};
		end else begin
			run_len = {1'b0, write_pos_q - retired_pos};
		end
		if (run_len > {1'b0, limit}) begin
			block_len = limit;
		end else begin
			block_len = run_len[LEN_W-1:0];
		end
	end

	// Request decode and pointer updates.
	always_comb begin
		write_pos_d   = write_pos_q;
		read_pos_d    = read_pos_q;
		pending_len_d = pending_len_q;
		frame_count_d = frame_count_q;
		ram_wr_en     = 1'b0;
		stage_d       = '0;
		case (ubrp_pkg::action_t'(action))
			ubrp_pkg::ACT_PUSH: begin
				if (!ring_full) begin
					ram_wr_en          = 1'b1;
					write_pos_d        = write_pos_q + POS_W'(1);
					stage_d.push_taken = 1'b1;
				end
			end
			ubrp_pkg::ACT_TICK: begin
				frame_count_d = frame_count_q + ubrp_pkg::FRAME_W'(1);
				if (fire) begin
					frame_count_d = '0;
					if (endpoint_idle) begin
						read_pos_d    = retired_pos;
						pending_len_d = '0;
						if (need_zlp) begin
							stage_d.send_valid         = 1'b1;
							stage_d.send_offset        = retired_pos;
							stage_d.zero_length_packet = 1'b1;
						end else if (retired_pos != write_pos_q) begin
							stage_d.send_valid  = 1'b1;
							stage_d.send_offset = retired_pos;
							stage_d.send_length = block_len;
							if (endpoint_accepts) begin
								pending_len_d = block_len;
							end
						end
					end
				end
			end
			ubrp_pkg::ACT_READ: begin
				stage_d.is_read = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Control state advances only on an accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_pos_q   <= '0;
			read_pos_q    <= '0;
			pending_len_q <= '0;
			frame_count_q <= '0;
		end else if (accept) begin
			write_pos_q   <= write_pos_d;
			read_pos_q    <= read_pos_d;
			pending_len_q <= pending_len_d;
			frame_count_q <= frame_count_d;
		end
	end

	// Ring storage; a read is issued for every accepted request so its data lines up with stage 1.
	ubrp_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (ubrp_pkg::RING_DEPTH)
	) u_ring (
		.clk     (clk),
		.wr_en   (accept && ram_wr_en),
		.wr_addr (write_pos_q),
		.wr_data (data_byte),
		.rd_en   (accept),
		.rd_addr (read_index),
		.rd_data (ram_rd_data)
	);

	// Stage 1 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			stage_s1 <= stage_d;
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_advance) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload; the pointers still reflect the stage 1 request when it moves on.
	always_ff @(posedge clk) begin
		if (s1_advance) begin
			out_q       <= stage_s1;
			free_q      <= read_pos_q - write_pos_q - POS_W'(1);
			read_data_q <= stage_s1.is_read ? ram_rd_data : '0;
		end
	end

	assign result_valid       = out_valid_q;
	assign push_taken         = out_q.push_taken;
	assign free_space         = free_q;
	assign send_valid         = out_q.send_valid;
	assign send_offset        = out_q.send_offset;
	assign send_length        = out_q.send_length;
	assign zero_length_packet = out_q.zero_length_packet;
	assign read_data          = read_data_q;

endmodule
`default_nettype wire

// ----- rtl/ubrp_checker.sv -----
// Port-level checks for the USB bulk-IN ring packetizer, bound to the top level.
`default_nettype none
module ubrp_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        result_valid,
	input wire logic                        result_stall,
	input wire logic                        push_taken,
	input wire logic                        send_valid,
	input wire logic [ubrp_pkg::LEN_W-1:0]  send_length,
	input wire logic                        zero_length_packet
);

	// A stalled result stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its transfer length and its send_valid flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(send_length) && $stable(send_valid))
		else $error("stalled result changed");

	// A zero-length packet is an offer that carries no bytes.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && zero_length_packet |-> send_valid && (send_length == '0))
		else $error("zero-length packet malformed");

	// Offered blocks never exceed the largest block, and a push never offers a transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (send_length <= ubrp_pkg::MAX_BLOCK) && !(push_taken && send_valid))
		else $error("offer out of range or mixed with push");

endmodule

bind usb_bulk_in_ring_packetizer_core ubrp_checker u_ubrp_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.result_valid       (result_valid),
	.result_stall       (result_stall),
	.push_taken         (push_taken),
	.send_valid         (send_valid),
	.send_length        (send_length),
	.zero_length_packet (zero_length_packet)
);
`default_nettype wire

// ----- tb/usb_bulk_in_ring_packetizer_core_tb.sv -----
// Self-checking testbench for the USB bulk-IN transmit ring packetizer core.
`timescale 1ns / 100ps

module usb_bulk_in_ring_packetizer_core_tb;

	localparam int unsigned BYTE_W     = ubrp_pkg::BYTE_W;
	localparam int unsigned POS_W      = ubrp_pkg::POS_W;
	localparam int unsigned LEN_W      = ubrp_pkg::LEN_W;
	localparam int unsigned FRAME_W    = ubrp_pkg::FRAME_W;
	localparam int unsigned DATA_W     = ubrp_pkg::DATA_W;
	localparam int unsigned ADDR_W     = ubrp_pkg::ADDR_W;
	localparam int unsigned RING_DEPTH = ubrp_pkg::RING_DEPTH;

	// Action code that the block must ignore.
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 500000;
	// Long receiver hold-off that backs the block up into its request side.
	localparam int unsigned HOLD_AT     = 300;
	localparam int unsigned HOLD_CYCLES = 60;
	localparam int unsigned N_PHASES    = 7;

	typedef struct packed {
		logic [1:0]        act;
		logic [BYTE_W-1:0] data;
		logic              ep_idle;
		logic              ep_accepts;
		logic [POS_W-1:0]  index;
	} ring_req_t;

	typedef struct packed {
		logic              push_taken;
		logic [POS_W-1:0]  free_space;
		logic              send_valid;
		logic [POS_W-1:0]  send_offset;
		logic [LEN_W-1:0]  send_length;
		logic              zero_length_packet;
		logic [BYTE_W-1:0] read_data;
	} ring_report_t;

	typedef struct packed {
		ring_req_t    rq;
		logic         typed;
		ring_report_t want;
	} opening_row_t;

	typedef struct {
		int unsigned interval_val;
		int unsigned limit_val;
		int unsigned items;
		int unsigned w_push;
		int unsigned w_tick;
		int unsigned w_read;
		int unsigned gap_max;
		int unsigned stall_max;
	} phase_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic item_valid;
	logic item_stall;
	logic [1:0] action;
	logic [BYTE_W-1:0] data_byte;
	logic endpoint_idle;
	logic endpoint_accepts;
	logic [POS_W-1:0] read_index;
	logic result_valid;
	logic result_stall;
	logic push_taken;
	logic [POS_W-1:0] free_space;
	logic send_valid;
	logic [POS_W-1:0] send_offset;
	logic [LEN_W-1:0] send_length;
	logic zero_length_packet;
	logic [BYTE_W-1:0] read_data;

	usb_bulk_in_ring_packetizer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.action(action),
		.data_byte(data_byte),
		.endpoint_idle(endpoint_idle),
		.endpoint_accepts(endpoint_accepts),
		.read_index(read_index),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.push_taken(push_taken),
		.free_space(free_space),
		.send_valid(send_valid),
		.send_offset(send_offset),
		.send_length(send_length),
		.zero_length_packet(zero_length_packet),
		.read_data(read_data)
	);

	// Shadow of the ring, its pointers and its registers.
	logic [BYTE_W-1:0]  ring_bytes [RING_DEPTH];
	logic [POS_W-1:0]   wr_pos;
	logic [POS_W-1:0]   rd_pos;
	logic [LEN_W-1:0]   pend_len;
	logic [FRAME_W-1:0] frame_cnt;
	logic [FRAME_W-1:0] interval_reg;
	logic [LEN_W-1:0]   limit_reg;
	// Positions below this count have been written, since pushes fill the ring in order.
	int unsigned written_top;

	ring_report_t due_reports [$];
	int unsigned mismatch_count;
	int unsigned results_seen;
	int unsigned cycle_count;
	int unsigned gap_max;
	int unsigned stall_max;

	// Opening requests under the reset settings: interval 5, block limit 512.
	opening_row_t opening_rows [25] = '{
		'{'{ACT_UNUSED, 8'hFF, 1'b1, 1'b1, 11'h7FF}, 1'b1,
			'{1'b0, 11'd2047, 1'b0, 11'd0, 11'd0, 1'b0, 8'h00}},
		'{'{ubrp_pkg::ACT_TICK, 8'h00, 1'b1, 1'b1, 11'd0}, 1'b1,
			'{1'b0, 11'd2047, 1'b0, 11'd0, 11'd0, 1'b0, 8'h00}},
		'{'{ubrp_pkg::ACT_PUSH, 8'h00, 1'b0, 1'b0, 11'd0}, 1'b1,
			'{1'b1, 11'd2046, 1'b0, 11'd0, 11'd0, 1'b0, 8'h00}},
		'{'{ubrp_pkg::ACT_PUSH, 8'hFF, 1'b1, 1'b1, 11'h7FF}, 1'b1,
			'{1'b1, 11'd2045, 1'b0, 11'd0, 11'd0, 1'b0, 8'h00}},
		'{'{ubrp_pkg::ACT_PUSH, 8'hA5, 1'b0, 1'b1, 11'd0}, 1'b1,
			'{1'b1, 11'd2044, 1'b0, 11'd0, 11'd0, 1'b0, 8'h00}},
		'{'{ubrp_pkg::ACT_READ, 8'hFF, 1'b1, 1'b1, 11'd0}, 1'b1,
			'{1'b0, 11'd2044, 1'b0, 11'd0, 11'd0, 1'b0, 8'h00}},
		'{'{ubrp_pkg::ACT_READ, 8'h00, 1'b0, 1'b0, 11'd1}, 1'b1,
			'{1'b0, 11'd2044, 1'b0, 11'd0, 11'd0, 1'b0, 8'hFF}},
		'{'{ubrp_pkg::ACT_READ, 8'h00, 1'b1, 1'b0, 11'd2}, 1'b1,
			'{1'b0, 11'd2044, 1'b0, 11'd0, 11'd0, 1'b0, 8'hA5}},
		'{'{ubrp_pkg::ACT_TICK, 8'h12, 1'b0, 1'b0, 11'd1}, 1'b0, '0},
		'{'{ubrp_pkg::ACT_TICK, 8'h34, 1'b1, 1'b0, 11'd2}, 1'b0, '0},
		'{'{ubrp_pkg::ACT_TICK, 8'h56, 1'b0, 1'b1, 11'd0}, 1'b0, '0},
		'{'{ubrp_pkg::ACT_TICK, 8'h78, 1'b1, 1'b1, 11'd1}, 1'b0, '0},
		// Scheduling point with the endpoint busy: nothing is offered.
		'{'{ubrp_pkg::ACT_TICK, 8'h00, 1'b0, 1'b1, 11'd0}, 1'b1,
			'{1'b0, 11'd2044, 1'b0, 11'd0, 11'd0, 1'b0, 8'h00}},
		'{'{ubrp_pkg::ACT_TICK, 8'h00, 1'b1, 1'b1, 11'd0}, 1'b0, '0},
		'{'{ubrp_pkg::ACT_TICK, 8'h00, 1'b0, 1'b0, 11'd0}, 1'b0, '0},
		'{'{ubrp_pkg::ACT_TICK, 8'h00, 1'b1, 1'b0, 11'd0}, 1'b0, '0},
		'{'{ubrp_pkg::ACT_TICK, 8'h00, 1'b0, 1'b1, 11'd0}, 1'b0, '0},
		'{'{ubrp_pkg::ACT_TICK, 8'h00, 1'b1, 1'b1, 11'd0}, 1'b0, '0},
		// Offer refused by the endpoint: still flagged, not remembered.
		'{'{ubrp_pkg::ACT_TICK, 8'h00, 1'b1, 1'b0, 11'd0}, 1'b1,
			'{1'b0, 11'd2044, 1'b1, 11'd0, 11'd3, 1'b0, 8'h00}},
		'{'{ubrp_pkg::ACT_TICK, 8'h00, 1'b1, 1'b1, 11'd0}, 1'b0, '0},
		'{'{ubrp_pkg::ACT_TICK, 8'h00, 1'b0, 1'b1, 11'd0}, 1'b0, '0},
		'{'{ubrp_pkg::ACT_TICK, 8'h00, 1'b1, 1'b0, 11'd0}, 1'b0, '0},
		'{'{ubrp_pkg::ACT_TICK, 8'h00, 1'b0, 1'b0, 11'd0}, 1'b0, '0},
		'{'{ubrp_pkg::ACT_TICK, 8'h00, 1'b1, 1'b1, 11'd0}, 1'b0, '0},
		// Same offer again, now taken by the endpoint.
		'{'{ubrp_pkg::ACT_TICK, 8'h00, 1'b1, 1'b1, 11'd0}, 1'b1,
			'{1'b0, 11'd2044, 1'b1, 11'd0, 11'd3, 1'b0, 8'h00}}
	};

	// Register settings and request mix of each random phase. The push-heavy phase builds a
	// long backlog under a wide interval, and the phase after it lowers the interval below
	// the frame count.
	phase_t plan [N_PHASES] = '{
		'{0,   64,   250, 50, 35, 12, 7, 7},
		'{1,   0,    150, 45, 40, 10, 7, 7},
		'{0,   2047, 150, 60, 30, 8,  3, 3},
		'{255, 1024, 300, 90, 8,  1,  1, 1},
		'{2,   1024, 300, 5,  88, 5,  7, 7},
		'{3,   64,   175, 50, 40, 8,  0, 0},
		'{0,   1000, 200, 45, 40, 12, 7, 7}
	};

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog on the total run length.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL usb_bulk_in_ring_packetizer_core");
		$finish;
	end

	// Apply one request to the shadow ring and return the result it must produce.
	function automatic ring_report_t advance_ring(input ring_req_t rq);
		ring_report_t rp;
		logic fire;
		logic zlp_sent;
		int unsigned lim;
		int unsigned span;
		rp = '0;
		case (rq.act)
			ubrp_pkg::ACT_PUSH: begin
				if (POS_W'(rd_pos - wr_pos - POS_W'(1)) != '0) begin
					ring_bytes[wr_pos] = rq.data;
					wr_pos = wr_pos + POS_W'(1);
					rp.push_taken = 1'b1;
					if (written_top < RING_DEPTH)
						written_top++;
				end
			end
			ubrp_pkg::ACT_TICK: begin
				fire = (frame_cnt == interval_reg);
				frame_cnt = frame_cnt + FRAME_W'(1);
				if (fire) begin
					frame_cnt = '0;
					zlp_sent = 1'b0;
					if (rq.ep_idle) begin
						// Retire the accepted block; a packet-size multiple ends with a ZLP.
						if (pend_len != '0) begin
							rd_pos = rd_pos + POS_W'(pend_len);
							zlp_sent = ((pend_len % ubrp_pkg::ZLP_UNIT) == 0);
							pend_len = '0;
							if (zlp_sent) begin
								rp.send_valid = 1'b1;
								rp.send_offset = rd_pos;
								rp.zero_length_packet = 1'b1;
							end
						end
						// Offer the next contiguous stretch up to the clamped limit.
						if (!zlp_sent && rd_pos != wr_pos) begin
							lim = limit_reg;
							if (lim == 0)
								lim = 1;
							if (lim > ubrp_pkg::MAX_BLOCK)
								lim = ubrp_pkg::MAX_BLOCK;
							if (rd_pos > wr_pos)
								span = RING_DEPTH - rd_pos;
							else
								span = wr_pos - rd_pos;
							if (span > lim)
								span = lim;
							rp.send_valid = 1'b1;
							rp.send_offset = rd_pos;
							rp.send_length = LEN_W'(span);
							if (rq.ep_accepts)
								pend_len = LEN_W'(span);
						end
					end
				end
			end
			ubrp_pkg::ACT_READ: rp.read_data = ring_bytes[rq.index];
			default: ;
		endcase
		rp.free_space = rd_pos - wr_pos - POS_W'(1);
		return rp;
	endfunction

	// Draw a random request from a phase's mix; reads stay inside the written part of the ring.
	function automatic ring_req_t draw_request(input phase_t ph);
		ring_req_t rq;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < ph.w_push)
			rq.act = ubrp_pkg::ACT_PUSH;
		else if (roll < ph.w_push + ph.w_tick)
			rq.act = ubrp_pkg::ACT_TICK;
		else if (roll < ph.w_push + ph.w_tick + ph.w_read)
			rq.act = ubrp_pkg::ACT_READ;
		else
			rq.act = ACT_UNUSED;
		if (rq.act == ubrp_pkg::ACT_READ && written_top == 0)
			rq.act = ubrp_pkg::ACT_PUSH;
		rq.data = BYTE_W'($urandom_range(0, 255));
		rq.ep_idle = ($urandom_range(0, 9) < 8);
		rq.ep_accepts = ($urandom_range(0, 9) < 8);
		rq.index = (written_top == 0) ? '0 : POS_W'($urandom_range(0, written_top - 1));
		return rq;
	endfunction

	task automatic note_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 50)
			$display("[%0t] mismatch on result %0d: %s", $realtime, results_seen, what);
	endtask

	task automatic check_report(input ring_report_t want);
		if (push_taken !== want.push_taken)
			note_mismatch($sformatf("push_taken %0d, want %0d", push_taken, want.push_taken));
		if (free_space !== want.free_space)
			note_mismatch($sformatf("free_space %0d, want %0d", free_space, want.free_space));
		if (send_valid !== want.send_valid)
			note_mismatch($sformatf("send_valid %0d, want %0d", send_valid, want.send_valid));
		if (send_offset !== want.send_offset)
			note_mismatch($sformatf("send_offset %0d, want %0d", send_offset,
				want.send_offset));
		if (send_length !== want.send_length)
			note_mismatch($sformatf("send_length %0d, want %0d", send_length,
				want.send_length));
		if (zero_length_packet !== want.zero_length_packet)
			note_mismatch($sformatf("zero_length_packet %0d, want %0d", zero_length_packet,
				want.zero_length_packet));
		if (read_data !== want.read_data)
			note_mismatch($sformatf("read_data %0h, want %0h", read_data, want.read_data));
	endtask

	// Offer one request after a random gap and hold it until the block takes it.
	task automatic drive_request(input ring_req_t rq, input logic typed,
			input ring_report_t want);
		int unsigned gap;
		ring_report_t got;
		gap = $urandom_range(0, gap_max);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		action <= rq.act;
		data_byte <= rq.data;
		endpoint_idle <= rq.ep_idle;
		endpoint_accepts <= rq.ep_accepts;
		read_index <= rq.index;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		got = advance_ring(rq);
		due_reports.push_back(typed ? want : got);
	endtask

	// Stop offering and wait for every due result, plus the pipeline depth.
	task automatic settle();
		item_valid <= 1'b0;
		while (due_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Register write: setup cycle, then access cycle until pready.
	task automatic write_reg(input ubrp_pkg::reg_idx_t idx, input int unsigned value);
		logic [DATA_W-1:0] mask;
		logic [DATA_W-1:0] word;
		mask = (idx == ubrp_pkg::REG_FRAME_INTERVAL) ? DATA_W'(32'hFF) : DATA_W'(32'h7FF);
		word = (DATA_W'($urandom()) & ~mask) | (DATA_W'(value) & mask);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == ubrp_pkg::REG_FRAME_INTERVAL)
			interval_reg = word[FRAME_W-1:0];
		else
			limit_reg = word[LEN_W-1:0];
		@(posedge clk);
	endtask

	// Result side: check each accepted result and stall at random, once for a long stretch.
	initial begin
		ring_report_t want;
		int unsigned wait_left;
		int unsigned hold_left;
		wait_left = 0;
		hold_left = 0;
		results_seen = 0;
		mismatch_count = 0;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_valid && !result_stall) begin
				results_seen++;
				if (due_reports.size() == 0) begin
					note_mismatch("result with no request outstanding");
				end else begin
					want = due_reports.pop_front();
					check_report(want);
				end
				wait_left = $urandom_range(0, stall_max);
				if (results_seen == HOLD_AT)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (wait_left != 0) begin
				wait_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// Request side and overall sequence.
	initial begin
		wr_pos = '0;
		rd_pos = '0;
		pend_len = '0;
		frame_cnt = '0;
		interval_reg = ubrp_pkg::FRAME_INTERVAL_RST;
		limit_reg = ubrp_pkg::BLOCK_LIMIT_RST;
		written_top = 0;
		gap_max = 7;
		stall_max = 7;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		item_valid <= 1'b0;
		action <= ubrp_pkg::ACT_PUSH;
		data_byte <= '0;
		endpoint_idle <= 1'b0;
		endpoint_accepts <= 1'b0;
		read_index <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening under the reset register values.
		foreach (opening_rows[i])
			drive_request(opening_rows[i].rq, opening_rows[i].typed, opening_rows[i].want);

		// Random phases, each under its own register settings.
		for (int p = 0; p < N_PHASES; p++) begin
			settle();
			write_reg(ubrp_pkg::REG_FRAME_INTERVAL, plan[p].interval_val);
			write_reg(ubrp_pkg::REG_BLOCK_LIMIT, plan[p].limit_val);
			gap_max = plan[p].gap_max;
			stall_max = plan[p].stall_max;
			repeat (plan[p].items)
				drive_request(draw_request(plan[p]), 1'b0, '0);
		end

		settle();
		if (mismatch_count == 0)
			$display("PASS usb_bulk_in_ring_packetizer_core");
		else
			$display("FAIL usb_bulk_in_ring_packetizer_core");
		$finish;
	end

endmodule
